FILE: design/brf_pkg.sv
// package for the byte ring fifo with prefix match
// transaction structs, mode codes, controller states and byte select helper
// no dependencies
`default_nettype none

package brf_pkg;

    localparam int LEVEL_W = 9;

    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_MATCH = 2'd1;
    localparam logic [1:0] MODE_DROP  = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] payload;
        logic [2:0]  byte_count;
        logic [15:0] drop_count;
    } brf_req_t;

    typedef struct packed {
        logic               ok;
        logic [LEVEL_W-1:0] level;
    } brf_rsp_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } brf_mem_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH,
        ST_MRD,
        ST_MCMP
    } brf_state_t;

    // byte sel of the payload word, bytes above bit 31 read as zero
    function automatic logic [7:0] pick_byte(input logic [31:0] word, input logic [2:0] sel);
        logic [7:0] res;
        case (sel)
            3'd0:    res = word[7:0];
            3'd1:    res = word[15:8];
            3'd2:    res = word[23:16];
            3'd3:    res = word[31:24];
            default: res = 8'h00;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: design/byte_ring_fifo_prefix_match.sv
// top level of the byte ring fifo with prefix match
// instantiates brf_ctrl and brf_mem, types from brf_pkg
//
//  channel   | handshake           | payload
//  ----------+---------------------+-------------------------------
//  request   | start in, busy out  | req : brf_req_t (mode, payload, byte_count, drop_count)
//  result    | done out, no stall  | rsp : brf_rsp_t (ok, level)
//
// drop, unknown mode, zero-length and refused requests: result in the cycle after start
// push of n bytes: one byte written per cycle in ST_PUSH, result after the last write
// match of n bytes: each byte is a read (ST_MRD) then a compare (ST_MCMP) on
// the single byte-wide store port with registered read data; a mismatch ends it early
// reset clears head and fill count; store contents stay undefined until pushed
`default_nettype none

module byte_ring_fifo_prefix_match
    import brf_pkg::*;
#(
    parameter int CAPACITY = 256,
    parameter int MAX_SPAN = 4
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire brf_req_t req,
    output logic          busy,
    output logic          done,
    output brf_rsp_t      rsp
);

    localparam int AW = $clog2(CAPACITY);

    brf_mem_ctl_t  mem_ctl;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [7:0]    mem_rdata;

    brf_ctrl #(
        .CAPACITY (CAPACITY),
        .MAX_SPAN (MAX_SPAN)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .done      (done),
        .rsp       (rsp),
        .mem_ctl   (mem_ctl),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    brf_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .clk   (clk),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

FILE: design/brf_mem.sv
// byte-wide single port store with registered read data
// depends on brf_pkg for the control struct
`default_nettype none

module brf_mem
    import brf_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  wire logic                     clk,
    input  wire brf_mem_ctl_t             ctl,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [7:0]               wdata,
    output logic [7:0]                    rdata
);

    logic [7:0] store_mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            store_mem[addr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= store_mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: design/brf_ctrl.sv
// controller of the byte ring fifo: head, fill count and sequencing of the store
// depends on brf_pkg; drives brf_mem through a control struct
`default_nettype none

module brf_ctrl
    import brf_pkg::*;
#(
    parameter int CAPACITY = 256,
    parameter int MAX_SPAN = 4
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire brf_req_t                    req,
    output logic                             busy,
    output logic                             done,
    output brf_rsp_t                         rsp,
    output brf_mem_ctl_t                     mem_ctl,
    output logic [$clog2(CAPACITY)-1:0]      mem_addr,
    output logic [7:0]                       mem_wdata,
    input  wire logic [7:0]                  mem_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);
    localparam int SW = FW + 1;
    localparam int DW = (FW > 16) ? FW : 16;
    localparam logic [SW-1:0] CAP_S = SW'(CAPACITY);
    localparam logic [AW:0]   CAP_A = (AW + 1)'(CAPACITY);
    localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);

    brf_state_t    state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [2:0]    idx_reg, idx_next;
    logic [2:0]    cnt_reg, cnt_next;
    logic [31:0]   pat_reg, pat_next;
    logic          done_reg, done_next;
    logic          ok_reg, ok_next;

    logic [SW-1:0] tail_sum;
    logic [AW-1:0] tail;
    logic          span_bad;
    logic          over;
    logic          short_fill;
    logic [DW-1:0] fill_d;
    logic [DW-1:0] drop_d;
    logic          keep;
    logic [AW:0]   head_sum;
    logic [AW-1:0] head_drop;
    logic [AW-1:0] ptr_inc;
    logic [7:0]    exp_byte;
    logic          last;

    always_comb
    begin
        tail_sum   = SW'(head_reg) + SW'(fill_reg);
        tail       = (tail_sum >= CAP_S) ? AW'(tail_sum - CAP_S) : AW'(tail_sum);
        span_bad   = {29'd0, req.byte_count} > 32'(MAX_SPAN);
        over       = (SW'(fill_reg) + SW'(req.byte_count)) > CAP_S;
        short_fill = SW'(fill_reg) < SW'(req.byte_count);
        fill_d     = DW'(fill_reg);
        drop_d     = DW'(req.drop_count);
        keep       = fill_d > drop_d;
        head_sum   = {1'b0, head_reg} + {1'b0, AW'(req.drop_count)};
        head_drop  = (head_sum >= CAP_A) ? AW'(head_sum - CAP_A) : AW'(head_sum);
        ptr_inc    = (ptr_reg == LAST_A) ? '0 : ptr_reg + 1'b1;
        exp_byte   = pick_byte(pat_reg, cnt_reg - 3'd1 - idx_reg);
        last       = idx_reg == (cnt_reg - 3'd1);
    end

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        fill_next  = fill_reg;
        ptr_next   = ptr_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        pat_next   = pat_reg;
        done_next  = 1'b0;
        ok_next    = ok_reg;
        mem_ctl    = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    pat_next = req.payload;
                    cnt_next = req.byte_count;
                    idx_next = 3'd0;
                    unique case (req.mode)
                        MODE_PUSH:
                        begin
                            if (span_bad || over)
                            begin
                                done_next = 1'b1;
                                ok_next   = 1'b0;
                            end
                            else if (req.byte_count == 3'd0)
                            begin
                                done_next = 1'b1;
                                ok_next   = 1'b1;
                            end
                            else
                            begin
                                ptr_next   = tail;
                                state_next = ST_PUSH;
                            end
                        end
                        MODE_MATCH:
                        begin
                            if (span_bad || short_fill)
                            begin
                                done_next = 1'b1;
                                ok_next   = 1'b0;
                            end
                            else if (req.byte_count == 3'd0)
                            begin
                                done_next = 1'b1;
                                ok_next   = 1'b1;
                            end
                            else
                            begin
                                ptr_next   = head_reg;
                                state_next = ST_MRD;
                            end
                        end
                        MODE_DROP:
                        begin
                            if (keep)
                            begin
                                head_next = head_drop;
                                fill_next = FW'(fill_d - drop_d);
                            end
                            else
                            begin
                                head_next = '0;
                                fill_next = '0;
                            end
                            done_next = 1'b1;
                            ok_next   = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            ok_next   = 1'b0;
                        end
                    endcase
                end
            end
            ST_PUSH:
            begin
                mem_ctl.wr_en = 1'b1;
                ptr_next      = ptr_inc;
                idx_next      = idx_reg + 3'd1;
                if (last)
                begin
                    fill_next  = fill_reg + FW'(cnt_reg);
                    done_next  = 1'b1;
                    ok_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_MRD:
            begin
                mem_ctl.rd_en = 1'b1;
                ptr_next      = ptr_inc;
                state_next    = ST_MCMP;
            end
            ST_MCMP:
            begin
                if (mem_rdata != exp_byte)
                begin
                    done_next  = 1'b1;
                    ok_next    = 1'b0;
                    state_next = ST_IDLE;
                end
                else if (last)
                begin
                    done_next  = 1'b1;
                    ok_next    = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + 3'd1;
                    state_next = ST_MRD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            fill_reg  <= '0;
            done_reg  <= 1'b0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            done_reg  <= done_next;
            ok_reg    <= ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        idx_reg <= idx_next;
        cnt_reg <= cnt_next;
        pat_reg <= pat_next;
    end

    assign busy      = state_reg != ST_IDLE;
    assign done      = done_reg;
    assign rsp.ok    = ok_reg;
    assign rsp.level = LEVEL_W'(fill_reg);
    assign mem_addr  = ptr_reg;
    assign mem_wdata = exp_byte;

endmodule

`default_nettype wire
